@@ hw/rtl/circular_queue_search_middle_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the circular queue search/middle unit
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_SEARCH_MIDDLE_UNIT_MACROS_SVH
`define CIRCULAR_QUEUE_SEARCH_MIDDLE_UNIT_MACROS_SVH

// Same-cycle implication
`define CQSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CQSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cqsm_pkg.sv @@
// ---------------------------------------------------------------------------
// cqsm_pkg
// Request codes and controller/datapath handshake types for the queue unit.
// ---------------------------------------------------------------------------
`default_nettype none

package cqsm_pkg;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  localparam int OCC_W  = 7;
  localparam int WORD_W = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // latch a new request, clear result flags
    logic exec;      // perform add/remove, start search
    logic scan;      // one search step
    logic mid_rd;    // read lower-middle word
    logic mid_cap;   // capture lower-middle word
    logic load_out;  // move result into output register
  } cqsm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_start; // search on a non-empty queue
    logic scan_done;  // every stored word has been read
    logic out_free;   // output register can take a result
  } cqsm_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/cqsm_req_if.sv @@
// ---------------------------------------------------------------------------
// cqsm_req_if
// Request channel: request kind and word, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface cqsm_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cqsm_rsp_if.sv @@
// ---------------------------------------------------------------------------
// cqsm_rsp_if
// Result channel: one result per request, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface cqsm_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] removed_value;
  logic               found;
  logic [6:0]         occupancy;
  logic signed [31:0] middle_value;

  modport source (output valid, output ok, output removed_value, output found,
                  output occupancy, output middle_value, input ready);
  modport sink   (input valid, input ok, input removed_value, input found,
                  input occupancy, input middle_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cqsm_ctrl.sv @@
// ---------------------------------------------------------------------------
// cqsm_ctrl
// Sequencer: accept, execute, search walk, middle read, result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module cqsm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cqsm_pkg::cqsm_sts_t sts,
  output cqsm_pkg::cqsm_cmd_t    cmd
);
  import cqsm_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_MID_RD   = 3'd3;
  localparam logic [2:0] S_MID_WAIT = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.scan_start ? S_SCAN : S_MID_RD;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_MID_RD;
        end
      end
      S_MID_RD: begin
        cmd.mid_rd = 1'b1;
        state_next = S_MID_WAIT;
      end
      S_MID_WAIT: begin
        cmd.mid_cap = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cqsm_datapath.sv @@
// ---------------------------------------------------------------------------
// cqsm_datapath
// Word memory, head/tail pointers, count, search compare and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module cqsm_datapath #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cqsm_pkg::cqsm_cmd_t  cmd,
  output cqsm_pkg::cqsm_sts_t       sts,
  input  wire logic [1:0]           req_type,
  input  wire logic signed [31:0]   item_value,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic                      ok,
  output logic signed [31:0]        removed_value,
  output logic                      found,
  output logic [6:0]                occupancy,
  output logic signed [31:0]        middle_value
);
  import cqsm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic signed [WORD_W-1:0] mem [QUEUE_DEPTH];
  logic signed [WORD_W-1:0] rdata;

  logic [1:0]               req_q;
  logic signed [WORD_W-1:0] val_q;
  logic [PTR_W-1:0]         head;
  logic [PTR_W-1:0]         tail;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         scan_k;
  logic                     ok_q;
  logic signed [WORD_W-1:0] removed_q;
  logic                     found_q;
  logic signed [WORD_W-1:0] middle_q;
  logic                     rm_pend;
  logic                     scan_pend;

  logic                     is_full;
  logic                     is_empty;
  logic                     do_add;
  logic                     do_remove;
  logic                     scan_issue;
  logic                     mid_issue;
  logic                     rd_en;
  logic [PTR_W-1:0]         rd_addr;
  logic [CNT_W-1:0]         cnt_m1;
  logic [PTR_W-1:0]         mid_off;

  // Pointer plus offset, both below the depth, folded back into range
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // Decode the current request against queue state
  always_comb begin
    is_full    = (count == FULL_CNT);
    is_empty   = (count == '0);
    do_add     = cmd.exec && (req_q == REQ_ADD) && !is_full;
    do_remove  = cmd.exec && (req_q == REQ_REMOVE) && !is_empty;
    scan_issue = cmd.scan && (scan_k != count);
    mid_issue  = cmd.mid_rd && !is_empty;
    cnt_m1     = count - 1'b1;
    mid_off    = PTR_W'(cnt_m1 >> 1);
    rd_en      = do_remove || scan_issue || mid_issue;
    if (scan_issue) begin
      rd_addr = wrap_add(head, scan_k[PTR_W-1:0]);
    end else if (mid_issue) begin
      rd_addr = wrap_add(head, mid_off);
    end else begin
      rd_addr = head;
    end
  end

  assign sts.scan_start = (req_q == REQ_SEARCH) && !is_empty;
  assign sts.scan_done  = (scan_k == count);
  assign sts.out_free   = !out_valid || out_ready;

  // Word memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_add) begin
      mem[tail] <= val_q;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Request latch, result flags and captured words
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q     <= req_type;
      val_q     <= item_value;
      ok_q      <= 1'b0;
      removed_q <= '0;
      found_q   <= 1'b0;
    end
    if (do_add || do_remove) begin
      ok_q <= 1'b1;
    end
    if (cmd.exec) begin
      scan_k <= '0;
    end else if (scan_issue) begin
      scan_k <= scan_k + 1'b1;
    end
    if (scan_pend && (rdata == val_q)) begin
      found_q <= 1'b1;
    end
    if (cmd.mid_rd && rm_pend) begin
      removed_q <= rdata;
    end
    if (cmd.mid_cap) begin
      middle_q <= is_empty ? '0 : rdata;
    end
  end

  // Pointers, count and read-tracking flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rm_pend   <= 1'b0;
      scan_pend <= 1'b0;
    end else begin
      rm_pend   <= do_remove;
      scan_pend <= scan_issue;
      if (do_add) begin
        tail  <= ptr_inc(tail);
        count <= count + 1'b1;
      end
      if (do_remove) begin
        head  <= ptr_inc(head);
        count <= count - 1'b1;
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ok            <= ok_q;
      removed_value <= removed_q;
      found         <= found_q;
      occupancy     <= OCC_W'(count);
      middle_value  <= middle_q;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/circular_queue_search_middle_unit.sv @@
// ---------------------------------------------------------------------------
// circular_queue_search_middle_unit
// Circular FIFO of signed words with add, remove-oldest and search requests.
// ---------------------------------------------------------------------------
// Each accepted request returns exactly one result carrying the outcome, the
// count after the step and the lower-middle stored word (offset (count-1)/2
// from the head, 0 when empty). Words sit in a single-port-read memory of
// QUEUE_DEPTH entries; every word read goes through its registered read port,
// one word per cycle. Add, remove, unused codes and a search on an empty
// queue go from acceptance via execute, middle read and capture to the
// result load, which waits while the output holds an untaken result; a
// non-empty search reads each stored word once, then compares the last;
// a new request is taken in the cycle after the load, while that result
// may still wait at the output. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_queue_search_middle_unit #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cqsm_req_if.sink   req,
  cqsm_rsp_if.source rsp
);
  import cqsm_pkg::*;

  cqsm_cmd_t cmd;
  cqsm_sts_t sts;

  cqsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cqsm_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req.req_type),
    .item_value    (req.item_value),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .ok            (rsp.ok),
    .removed_value (rsp.removed_value),
    .found         (rsp.found),
    .occupancy     (rsp.occupancy),
    .middle_value  (rsp.middle_value)
  );

endmodule

`default_nettype wire

@@ hw/rtl/cqsm_checker.sv @@
// ---------------------------------------------------------------------------
// cqsm_checker
// Port-level checks on the result channel of the queue unit.
// ---------------------------------------------------------------------------
`default_nettype none

`include "circular_queue_search_middle_unit_macros.svh"

module cqsm_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        ok,
  input wire logic [31:0] removed_value,
  input wire logic        found,
  input wire logic [6:0]  occupancy,
  input wire logic [31:0] middle_value
);

  // Stalled result holds
  `CQSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(ok) && $stable(removed_value) && $stable(found) && $stable(occupancy) && $stable(middle_value), "result changed while stalled")

  // Count never exceeds the capacity
  `CQSM_ASSERT_NOW(a_occ_range, rsp_valid && (QUEUE_DEPTH < 128), occupancy <= 7'(QUEUE_DEPTH), "occupancy above capacity")

  // Empty queue reports no middle word and no match
  `CQSM_ASSERT_NOW(a_empty, rsp_valid && (occupancy == 7'd0) && (QUEUE_DEPTH < 128), (middle_value == 32'd0) && !found, "empty queue with middle word or match")

  // A search result carries no success and no removed word
  `CQSM_ASSERT_NOW(a_found_excl, rsp_valid && found, !ok && (removed_value == 32'd0), "match reported with add/remove outcome")

  // Removed word only with success
  `CQSM_ASSERT_NOW(a_removed_ok, rsp_valid && !ok, removed_value == 32'd0, "removed word without success")

endmodule

bind circular_queue_search_middle_unit cqsm_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_cqsm_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .ok            (rsp.ok),
  .removed_value (rsp.removed_value),
  .found         (rsp.found),
  .occupancy     (rsp.occupancy),
  .middle_value  (rsp.middle_value)
);

`default_nettype wire
